/* src/tfzm_pkg.sv */
// ----------------------------------------------------------------------------
// tfzm_pkg
// Shared constants and types for the multisample z-buffered fragment shader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tfzm_pkg;

  // screen size and depth store geometry
  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 256;
  localparam int DEPTH_N       = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W        = (DEPTH_N > 1) ? $clog2(DEPTH_N) : 1;

  // depth format, signed Q4.20
  localparam int Z_W = 24;
  localparam logic signed [Z_W-1:0] DEPTH_FAR      = 24'sh7FFFFF;
  localparam logic signed [Z_W-1:0] DEPTH_NEAR_MIN = 24'sh800000;

  // datapath widths
  localparam int EDGE_W = 36;  // edge function values
  localparam int ACC_W  = 60;  // barycentric depth sum
  localparam int NUM_W  = 60;  // dividend magnitude, also quotient
  localparam int DEN_W  = 35;  // divisor magnitude
  localparam int MA_W   = 19;  // shared multiplier operand a
  localparam int MB_W   = 25;  // shared multiplier operand b
  localparam int P_W    = MA_W + MB_W;
  localparam int SPLIT  = 18;  // low part width when splitting an edge value

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SHADE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE,
    ST_COVER,
    ST_DEPTH,
    ST_DIVPREP,
    ST_DIV,
    ST_FINAL,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* src/triangle_fragment_zbuffer_msaa_top.sv */
// ----------------------------------------------------------------------------
// triangle_fragment_zbuffer_msaa_top
// Fragment shader with 4x sub-sample coverage and a depth buffer in memory.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+----------------------------------
//   input   | in        | in_valid/in_stall | op, vertex_sel, vert_*, tri_*, pix_*
//   output  | out       | out_valid/out_stall | written, out_x/y, out_rgb, depth, cov
//
// One item at a time. A covered pixel's time is dominated by the
// 60-step restoring divider; the edge and depth products share one multiplier.
// Loads, clears, dropped and uncovered pixels skip the depth and divide steps.
// After reset a clearing pass writes far depth into every entry, one a cycle,
// SCREEN_WIDTH*SCREEN_HEIGHT (65536) entries in all, with in_stall held high.
// A result waiting behind out_stall does not block acceptance of the next item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_fragment_zbuffer_msaa_top
  import tfzm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        op,
  input  wire logic [1:0]        vertex_sel,
  input  wire logic [15:0]       vert_x,
  input  wire logic [15:0]       vert_y,
  input  wire logic signed [23:0] vert_z,
  input  wire logic [7:0]        tri_red,
  input  wire logic [7:0]        tri_green,
  input  wire logic [7:0]        tri_blue,
  input  wire logic [11:0]       pix_x,
  input  wire logic [11:0]       pix_y,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   written,
  output logic [11:0]            out_x,
  output logic [11:0]            out_y,
  output logic [7:0]             out_red,
  output logic [7:0]             out_green,
  output logic [7:0]             out_blue,
  output logic signed [23:0]     out_depth,
  output logic [2:0]             coverage
);

  // helpers
  function automatic logic signed [EDGE_W-1:0] edge_at(
    input logic signed [EDGE_W-1:0] e,
    input logic signed [16:0]       ddx,
    input logic signed [16:0]       ddy,
    input logic [1:0]               ox,
    input logic [1:0]               oy
  );
    logic signed [EDGE_W-1:0] tx;
    logic signed [EDGE_W-1:0] ty;
    tx = ox[1] ? (EDGE_W'(ddy) <<< 3) : (ox[0] ? (EDGE_W'(ddy) <<< 2) : '0);
    ty = oy[1] ? (EDGE_W'(ddx) <<< 3) : (oy[0] ? (EDGE_W'(ddx) <<< 2) : '0);
    return e + tx - ty;
  endfunction

  function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [2:0] n);
    logic [10:0] t;
    t = 11'(c) * 11'(n) + 11'd2;
    return t[9:2];
  endfunction

  // control state
  state_t            state;
  state_t            state_next;
  logic [5:0]        step;
  logic [ADDR_W-1:0] clr_idx;
  logic              accept;

  // vertex and colour store
  logic [15:0]           vtx_x [3];
  logic [15:0]           vtx_y [3];
  logic signed [Z_W-1:0] vtx_z [3];
  logic [23:0]           color;

  // pixel under work
  logic [11:0] px_q;
  logic [11:0] py_q;

  // depth memory
  logic signed [Z_W-1:0] depth_mem [DEPTH_N];
  logic [ADDR_W-1:0]     rd_addr;
  logic signed [Z_W-1:0] rd_data;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_wa;
  logic signed [Z_W-1:0] mem_wd;

  // arithmetic
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [P_W-1:0]    prod;
  logic signed [EDGE_W-1:0] tmp_q;
  logic signed [EDGE_W-1:0] edge_q [4];
  logic signed [EDGE_W-1:0] nc_q [3];
  logic signed [ACC_W-1:0]  acc;
  logic [NUM_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic [DEN_W-1:0]         rem;
  logic                     neg_q;

  // staged result
  logic              r_written;
  logic [11:0]       r_x;
  logic [11:0]       r_y;
  logic [7:0]        r_red;
  logic [7:0]        r_green;
  logic [7:0]        r_blue;
  logic signed [23:0] r_depth;
  logic [2:0]        r_cov;

  // input decode
  logic              in_screen;
  logic [24:0]       in_addr_full;
  logic [ADDR_W-1:0] in_addr;

  assign in_screen    = ({1'b0, pix_x} < 13'(SCREEN_WIDTH)) &&
                        ({1'b0, pix_y} < 13'(SCREEN_HEIGHT));
  assign in_addr_full = 25'(pix_y) * 25'(SCREEN_WIDTH) + 25'(pix_x);
  assign in_addr      = in_addr_full[ADDR_W-1:0];
  assign accept       = in_valid && !in_stall;

  // edge direction terms
  logic signed [16:0] edx [3];
  logic signed [16:0] edy [3];

  always_comb begin
    edx[0] = $signed({1'b0, vtx_x[1]}) - $signed({1'b0, vtx_x[0]});
    edy[0] = $signed({1'b0, vtx_y[1]}) - $signed({1'b0, vtx_y[0]});
    edx[1] = $signed({1'b0, vtx_x[2]}) - $signed({1'b0, vtx_x[1]});
    edy[1] = $signed({1'b0, vtx_y[2]}) - $signed({1'b0, vtx_y[1]});
    edx[2] = $signed({1'b0, vtx_x[0]}) - $signed({1'b0, vtx_x[2]});
    edy[2] = $signed({1'b0, vtx_y[0]}) - $signed({1'b0, vtx_y[2]});
  end

  // sub-sample coverage from the base-sample edge values
  logic [3:0]               samp_in;
  logic [2:0]               cov_cnt;
  logic signed [EDGE_W-1:0] ctr_e [3];

  always_comb begin
    logic signed [EDGE_W-1:0] v;
    logic all_ge;
    logic all_le;
    for (int s = 0; s < 4; s++) begin
      all_ge = 1'b1;
      all_le = 1'b1;
      for (int e = 0; e < 3; e++) begin
        v = edge_at(edge_q[e], edx[e], edy[e], s[1] ? 2'd2 : 2'd0, s[0] ? 2'd2 : 2'd0);
        if (v[EDGE_W-1]) all_ge = 1'b0;
        if (!v[EDGE_W-1] && (v != '0)) all_le = 1'b0;
      end
      samp_in[s] = all_ge || all_le;
    end
    for (int e = 0; e < 3; e++) begin
      ctr_e[e] = edge_at(edge_q[e], edx[e], edy[e], 2'd1, 2'd1);
    end
    cov_cnt = 3'($countones(samp_in));
  end

  // shared multiplier operand select
  always_comb begin
    logic [15:0] ax, ay, bx, by, qx, qy;
    logic signed [16:0] d_px, d_py, d_bx, d_by;
    logic signed [EDGE_W-1:0] nsel;
    logic signed [Z_W-1:0]    zsel;
    ax = vtx_x[0]; ay = vtx_y[0]; bx = vtx_x[1]; by = vtx_y[1];
    qx = {px_q, 4'd4}; qy = {py_q, 4'd4};
    d_px = '0; d_py = '0; d_bx = '0; d_by = '0;
    nsel = nc_q[1];
    zsel = vtx_z[0];
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_EDGE: begin
        case (step[2:1])
          2'd0: begin
            ax = vtx_x[0]; ay = vtx_y[0]; bx = vtx_x[1]; by = vtx_y[1];
          end
          2'd1: begin
            ax = vtx_x[1]; ay = vtx_y[1]; bx = vtx_x[2]; by = vtx_y[2];
          end
          2'd2: begin
            ax = vtx_x[2]; ay = vtx_y[2]; bx = vtx_x[0]; by = vtx_y[0];
          end
          default: begin
            // divisor: edge v1->v2 evaluated at v0
            ax = vtx_x[1]; ay = vtx_y[1]; bx = vtx_x[2]; by = vtx_y[2];
            qx = vtx_x[0]; qy = vtx_y[0];
          end
        endcase
        d_px = $signed({1'b0, qx}) - $signed({1'b0, ax});
        d_py = $signed({1'b0, qy}) - $signed({1'b0, ay});
        d_bx = $signed({1'b0, bx}) - $signed({1'b0, ax});
        d_by = $signed({1'b0, by}) - $signed({1'b0, ay});
        mul_a = step[0] ? MA_W'(d_py) : MA_W'(d_px);
        mul_b = step[0] ? MB_W'(d_bx) : MB_W'(d_by);
      end
      ST_DEPTH: begin
        case (step[2:1])
          2'd0:    begin nsel = nc_q[1]; zsel = vtx_z[0]; end
          2'd1:    begin nsel = nc_q[2]; zsel = vtx_z[1]; end
          default: begin nsel = nc_q[0]; zsel = vtx_z[2]; end
        endcase
        // split the edge value into unsigned low and signed high parts
        mul_a = step[0] ? MA_W'($signed(nsel[EDGE_W-1:SPLIT]))
                        : $signed({1'b0, nsel[SPLIT-1:0]});
        mul_b = MB_W'(zsel);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // final depth saturation and test
  logic signed [Z_W-1:0] z_fin;
  logic                  z_pass;

  always_comb begin
    if (neg_q) begin
      z_fin = (div_num > NUM_W'(24'd8388608)) ? DEPTH_NEAR_MIN : Z_W'(~div_num[23:0] + 24'd1);
    end else begin
      z_fin = (div_num > NUM_W'(24'd8388607)) ? DEPTH_FAR : $signed(div_num[23:0]);
    end
    z_pass = (z_fin <= rd_data);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (clr_idx == ADDR_W'(DEPTH_N - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          state_next = (op == OP_SHADE && in_screen) ? ST_EDGE : ST_DONE;
        end
      end
      ST_EDGE:    if (step == 6'd8) state_next = ST_COVER;
      ST_COVER: begin
        state_next = (cov_cnt == 3'd0 || edge_q[3] == '0) ? ST_DONE : ST_DEPTH;
      end
      ST_DEPTH:   if (step == 6'd6) state_next = ST_DIVPREP;
      ST_DIVPREP: state_next = ST_DIV;
      ST_DIV:     if (step == 6'(NUM_W - 1)) state_next = ST_FINAL;
      ST_FINAL:   state_next = ST_DONE;
      ST_DONE:    if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // control outputs and memory write port
  always_comb begin
    in_stall = (state != ST_IDLE);
    mem_we   = 1'b0;
    mem_wa   = rd_addr;
    mem_wd   = DEPTH_FAR;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_idx;
      end
      ST_IDLE: begin
        mem_we = in_valid && op == OP_CLEAR && in_screen;
        mem_wa = in_addr;
      end
      ST_FINAL: begin
        mem_we = z_pass;
        mem_wd = z_fin;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // depth memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      depth_mem[mem_wa] <= mem_wd;
    end
    rd_data <= depth_mem[rd_addr];
  end

  // state register and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      step    <= '0;
    end else begin
      state   <= state_next;
      step    <= (state_next != state) ? 6'd0 : step + 6'd1;
      if (state == ST_CLEAR) clr_idx <= clr_idx + ADDR_W'(1);
    end
  end

  // colour store
  always_ff @(posedge clk) begin
    if (rst) begin
      color <= '0;
    end else if (accept && op == OP_LOAD && vertex_sel == 2'd0) begin
      color <= {tri_red, tri_green, tri_blue};
    end
  end

  // vertex store
  always_ff @(posedge clk) begin
    if (accept && op == OP_LOAD && vertex_sel != 2'd3) begin
      vtx_x[vertex_sel] <= vert_x;
      vtx_y[vertex_sel] <= vert_y;
      vtx_z[vertex_sel] <= vert_z;
    end
  end

  // shading datapath
  always_ff @(posedge clk) begin
    logic [ACC_W-1:0]   an;
    logic [EDGE_W-1:0]  ad;
    logic [DEN_W:0]     trial;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          px_q      <= pix_x;
          py_q      <= pix_y;
          rd_addr   <= in_addr;
          r_written <= 1'b0;
          r_x       <= (op == OP_SHADE) ? pix_x : 12'd0;
          r_y       <= (op == OP_SHADE) ? pix_y : 12'd0;
          r_red     <= '0;
          r_green   <= '0;
          r_blue    <= '0;
          r_depth   <= '0;
          r_cov     <= '0;
        end
      end
      ST_EDGE: begin
        // product of the previous step arrives now, edges land at steps 2, 4, 6, 8
        if (step != 6'd0) begin
          if (!step[0]) begin
            edge_q[2'(step[3:1] - 3'd1)] <= tmp_q - EDGE_W'(prod);
          end else begin
            tmp_q <= EDGE_W'(prod);
          end
        end
      end
      ST_COVER: begin
        r_cov <= cov_cnt;
        for (int e = 0; e < 3; e++) nc_q[e] <= ctr_e[e];
      end
      ST_DEPTH: begin
        if (step == 6'd0) begin
          acc <= '0;
        end else if (step[0]) begin
          acc <= acc + ACC_W'(prod);
        end else begin
          acc <= acc + (ACC_W'(prod) <<< SPLIT);
        end
      end
      ST_DIVPREP: begin
        an      = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        ad      = edge_q[3][EDGE_W-1] ? EDGE_W'(-edge_q[3]) : EDGE_W'(edge_q[3]);
        div_den <= ad[DEN_W-1:0];
        div_num <= NUM_W'(an) + NUM_W'(ad[DEN_W-1:1]);
        rem     <= '0;
        neg_q   <= acc[ACC_W-1] ^ edge_q[3][EDGE_W-1];
      end
      ST_DIV: begin
        // one restoring step per cycle, quotient shifts in behind the dividend
        trial = {rem, div_num[NUM_W-1]};
        if (trial >= {1'b0, div_den}) begin
          rem     <= DEN_W'(trial - {1'b0, div_den});
          div_num <= {div_num[NUM_W-2:0], 1'b1};
        end else begin
          rem     <= trial[DEN_W-1:0];
          div_num <= {div_num[NUM_W-2:0], 1'b0};
        end
      end
      ST_FINAL: begin
        if (z_pass) begin
          r_written <= 1'b1;
          r_red     <= scale_chan(color[23:16], r_cov);
          r_green   <= scale_chan(color[15:8], r_cov);
          r_blue    <= scale_chan(color[7:0], r_cov);
          r_depth   <= z_fin;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      written   <= r_written;
      out_x     <= r_x;
      out_y     <= r_y;
      out_red   <= r_red;
      out_green <= r_green;
      out_blue  <= r_blue;
      out_depth <= r_depth;
      coverage  <= r_cov;
    end
  end

`ifndef ASSERT_OFF
  // one item in flight: an accepted item closes the input side
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input taken while an item was in flight");

  // a written pixel always has coverage
  a_written_cov: assert property (@(posedge clk) disable iff (rst)
    out_valid && written |-> coverage != 3'd0)
    else $error("pixel written with no coverage");

  // a written pixel lies on the screen
  a_written_onscreen: assert property (@(posedge clk) disable iff (rst)
    out_valid && written |-> ({1'b0, out_x} < 13'(SCREEN_WIDTH)) &&
                             ({1'b0, out_y} < 13'(SCREEN_HEIGHT)))
    else $error("pixel written off screen");

  // coverage never exceeds four sub-samples
  a_cov_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> coverage <= 3'd4)
    else $error("coverage out of range");
`endif

endmodule

`default_nettype wire

/* dv/tb_triangle_fragment_zbuffer_msaa_top.sv */
// ----------------------------------------------------------------------------
// tb_triangle_fragment_zbuffer_msaa_top
// Self-checking bench for the 4x multisample z-buffered fragment shader.
// A driver pops queued vertex loads, pixel shades, depth clears and no-ops. An
// in-bench shading model predicts every result. A monitor compares each
// result, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_triangle_fragment_zbuffer_msaa_top;
  import tfzm_pkg::*;

  typedef struct {
    op_t                op;
    logic [1:0]         sel;
    logic [15:0]        vx;
    logic [15:0]        vy;
    logic signed [23:0] vz;
    logic [7:0]         r, g, b;
    logic [11:0]        px, py;
  } frag_item_t;

  typedef struct {
    logic               wr;
    logic [11:0]        x, y;
    logic [7:0]         r, g, b;
    logic signed [23:0] z;
    logic [2:0]         cov;
  } pixel_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = OP_NONE;
  logic [1:0] vertex_sel = '0;
  logic [15:0] vert_x = '0, vert_y = '0;
  logic signed [23:0] vert_z = '0;
  logic [7:0] tri_red = '0, tri_green = '0, tri_blue = '0;
  logic [11:0] pix_x = '0, pix_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic written;
  logic [11:0] out_x, out_y;
  logic [7:0] out_red, out_green, out_blue;
  logic signed [23:0] out_depth;
  logic [2:0] coverage;

  triangle_fragment_zbuffer_msaa_top i_dut (.*);

  initial forever #2 clk = ~clk;

  // shading model state
  longint     tri_x[3], tri_y[3], tri_z[3];
  logic [23:0] tri_rgb = '0;
  int         zbuf[SCREEN_WIDTH*SCREEN_HEIGHT];

  frag_item_t pending_items[$];
  pixel_out_t expected_pixels[$];
  int  mismatches = 0;
  int  accepted = 0, received = 0, n_written = 0, n_partial = 0, n_uncovered = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  function automatic longint edge_val(longint ax, ay, bx, by, qx, qy);
    return (qx - ax) * (by - ay) - (qy - ay) * (bx - ax);
  endfunction

  function automatic pixel_out_t shade_model(frag_item_t it);
    pixel_out_t o;
    longint sx, sy, e1, e2, e3, cx, cy, den, num, an, ad, q;
    int cnt, idx;
    o = '{default: '0};
    case (it.op)
      OP_LOAD: begin
        if (it.sel < 3) begin
          tri_x[it.sel] = it.vx;
          tri_y[it.sel] = it.vy;
          tri_z[it.sel] = it.vz;
          if (it.sel == 0) tri_rgb = {it.r, it.g, it.b};
        end
      end
      OP_CLEAR: begin
        if (it.px < SCREEN_WIDTH && it.py < SCREEN_HEIGHT)
          zbuf[it.py * SCREEN_WIDTH + it.px] = DEPTH_FAR;
      end
      OP_SHADE: begin
        o.x = it.px;
        o.y = it.py;
        if (it.px < SCREEN_WIDTH && it.py < SCREEN_HEIGHT) begin
          cnt = 0;
          // four sub-samples at quarter offsets, either winding
          for (int s = 0; s < 4; s++) begin
            sx = longint'(it.px) * 16 + ((s & 2) ? 12 : 4);
            sy = longint'(it.py) * 16 + ((s & 1) ? 12 : 4);
            e1 = edge_val(tri_x[0], tri_y[0], tri_x[1], tri_y[1], sx, sy);
            e2 = edge_val(tri_x[1], tri_y[1], tri_x[2], tri_y[2], sx, sy);
            e3 = edge_val(tri_x[2], tri_y[2], tri_x[0], tri_y[0], sx, sy);
            if ((e1 >= 0 && e2 >= 0 && e3 >= 0) || (e1 <= 0 && e2 <= 0 && e3 <= 0))
              cnt++;
          end
          o.cov = 3'(cnt);
          den = edge_val(tri_x[1], tri_y[1], tri_x[2], tri_y[2], tri_x[0], tri_y[0]);
          if (cnt > 0 && den != 0) begin
            cx = longint'(it.px) * 16 + 8;
            cy = longint'(it.py) * 16 + 8;
            num = edge_val(tri_x[1], tri_y[1], tri_x[2], tri_y[2], cx, cy) * tri_z[0]
                + edge_val(tri_x[2], tri_y[2], tri_x[0], tri_y[0], cx, cy) * tri_z[1]
                + edge_val(tri_x[0], tri_y[0], tri_x[1], tri_y[1], cx, cy) * tri_z[2];
            // rounded division, ties away from zero, then saturate
            an = num < 0 ? -num : num;
            ad = den < 0 ? -den : den;
            q = (an + ad / 2) / ad;
            if ((num < 0) != (den < 0)) q = -q;
            if (q > 8388607) q = 8388607;
            if (q < -8388608) q = -8388608;
            idx = it.py * SCREEN_WIDTH + it.px;
            if (q <= zbuf[idx]) begin
              zbuf[idx] = int'(q);
              o.wr = 1'b1;
              o.r = 8'((tri_rgb[23:16] * cnt + 2) >> 2);
              o.g = 8'((tri_rgb[15:8] * cnt + 2) >> 2);
              o.b = 8'((tri_rgb[7:0] * cnt + 2) >> 2);
              o.z = 24'(q);
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic void add_item(op_t o, logic [1:0] s, logic [15:0] x, y,
                                   logic signed [23:0] z, logic [7:0] r, g, b,
                                   logic [11:0] qx, qy);
    pending_items.push_back('{o, s, x, y, z, r, g, b, qx, qy});
  endfunction

  function automatic logic [15:0] rand_coord(bit wide);
    return wide ? 16'($urandom) : 16'($urandom_range(0, SCREEN_WIDTH * 16 + 64));
  endfunction

  // one triangle, degenerate when flat is set, followed by pixels inside its bounding box
  function automatic int add_triangle(int npix, bit wide, bit flat);
    logic [15:0] x[3], y[3];
    int xmin, xmax, ymin, ymax;
    for (int v = 0; v < 3; v++) begin
      x[v] = rand_coord(wide);
      y[v] = rand_coord(wide);
    end
    if (flat) begin
      x[2] = x[1];
      x[0] = x[1];
    end
    for (int v = 0; v < 3; v++)
      add_item(OP_LOAD, 2'(v), x[v], y[v], 24'($urandom), 8'($urandom),
               8'($urandom), 8'($urandom), 12'($urandom), 12'($urandom));
    xmin = x[0] >> 4; xmax = xmin; ymin = y[0] >> 4; ymax = ymin;
    for (int v = 1; v < 3; v++) begin
      if ((x[v] >> 4) < xmin) xmin = x[v] >> 4;
      if ((x[v] >> 4) > xmax) xmax = x[v] >> 4;
      if ((y[v] >> 4) < ymin) ymin = y[v] >> 4;
      if ((y[v] >> 4) > ymax) ymax = y[v] >> 4;
    end
    for (int p = 0; p < npix; p++)
      add_item(OP_SHADE, 2'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
               8'($urandom), 8'($urandom), 8'($urandom),
               12'($urandom_range(xmin, xmax)), 12'($urandom_range(ymin, ymax)));
    return 3 + npix;
  endfunction

  // driver: acceptance feeds the model, then the next item is offered
  always @(posedge clk) begin
    frag_item_t it;
    logic       next_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        it = pending_items.pop_front();
        expected_pixels.push_back(shade_model(it));
        accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid && pending_items.size() > 0 &&
          ((accepted > 500 && accepted < 800) || $urandom_range(0, 99) >= 29)) begin
        it = pending_items[0];
        op <= it.op; vertex_sel <= it.sel;
        vert_x <= it.vx; vert_y <= it.vy; vert_z <= it.vz;
        tri_red <= it.r; tri_green <= it.g; tri_blue <= it.b;
        pix_x <= it.px; pix_y <= it.py;
        next_valid = 1'b1;
      end
      in_valid <= next_valid;
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    pixel_out_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        received++;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer at %0t", $time);
        end else begin
          e = expected_pixels.pop_front();
          if (e.wr) n_written++;
          if (e.cov != 0 && e.cov != 4) n_partial++;
          if (e.cov == 0) n_uncovered++;
          if ({written, out_x, out_y, out_red, out_green, out_blue, out_depth, coverage}
              !== {e.wr, e.x, e.y, e.r, e.g, e.b, e.z, e.cov}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d: exp wr=%0d xy=%0d,%0d rgb=%0d,%0d,%0d z=%0d cov=%0d %s",
                       received, e.wr, e.x, e.y, e.r, e.g, e.b, e.z, e.cov,
                       $sformatf("got wr=%0d xy=%0d,%0d rgb=%0d,%0d,%0d z=%0d cov=%0d",
                                 written, out_x, out_y, out_red, out_green, out_blue,
                                 out_depth, coverage));
          end
        end
      end
      // receiver stall: one long hold-off, a calm stretch, random otherwise
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && received == 300) begin
        hold_done <= 1'b1;
        hold_left <= 1500;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !(received > 900 && received < 1200) && $urandom_range(0, 99) < 29;
      end
    end
  end

  // watchdog on cycles without any transfer, covers the clearing pass too
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 200000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int n;
    for (int i = 0; i < SCREEN_WIDTH * SCREEN_HEIGHT; i++) zbuf[i] = DEPTH_FAR;
    // directed: extremes of the vertex fields, every op, special cases
    add_item(OP_LOAD, 2'd0, 16'd0, 16'd0, 24'sh7FFFFF, 8'hFF, 8'h00, 8'hFF, 12'd0, 12'd0);
    add_item(OP_LOAD, 2'd1, 16'd4096, 16'd0, 24'sh800000, 8'h00, 8'hFF, 8'h00, 12'hFFF, 12'hFFF);
    add_item(OP_LOAD, 2'd2, 16'd0, 16'd4096, 24'sh000000, 8'h00, 8'h00, 8'h00, 12'd0, 12'd0);
    add_item(OP_SHADE, 2'd0, 16'd0, 16'd0, 24'sd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
    add_item(OP_SHADE, 2'd0, 16'd0, 16'd0, 24'sd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
    add_item(OP_SHADE, 2'd0, 16'd0, 16'd0, 24'sd0, 8'd0, 8'd0, 8'd0, 12'd127, 12'd128);
    add_item(OP_SHADE, 2'd0, 16'd0, 16'd0, 24'sd0, 8'd0, 8'd0, 8'd0, 12'd255, 12'd0);
    add_item(OP_SHADE, 2'd0, 16'd0, 16'd0, 24'sd0, 8'd0, 8'd0, 8'd0, 12'd255, 12'd255);
    add_item(OP_SHADE, 2'd0, 16'd0, 16'd0, 24'sd0, 8'd0, 8'd0, 8'd0, 12'hFFF, 12'd3);
    add_item(OP_SHADE, 2'd0, 16'd0, 16'd0, 24'sd0, 8'd0, 8'd0, 8'd0, 12'd3, 12'hFFF);
    add_item(OP_CLEAR, 2'd0, 16'd0, 16'd0, 24'sd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
    add_item(OP_CLEAR, 2'd0, 16'd0, 16'd0, 24'sd0, 8'd0, 8'd0, 8'd0, 12'hFFF, 12'hFFF);
    add_item(OP_SHADE, 2'd0, 16'd0, 16'd0, 24'sd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
    add_item(OP_NONE, 2'd0, 16'hFFFF, 16'hFFFF, 24'sd1, 8'd1, 8'd1, 8'd1, 12'd1, 12'd1);
    add_item(OP_LOAD, 2'd3, 16'hFFFF, 16'hFFFF, 24'sd5, 8'd9, 8'd9, 8'd9, 12'd0, 12'd0);
    // huge triangle reaching the top of the coordinate range
    add_item(OP_LOAD, 2'd0, 16'hFFFF, 16'd0, 24'sh7FFFFF, 8'd1, 8'd2, 8'd3, 12'd0, 12'd0);
    add_item(OP_LOAD, 2'd1, 16'd0, 16'hFFFF, 24'sh800000, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
    add_item(OP_LOAD, 2'd2, 16'hFFFF, 16'hFFFF, 24'sh7FFFFF, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
    add_item(OP_SHADE, 2'd0, 16'd0, 16'd0, 24'sd0, 8'd0, 8'd0, 8'd0, 12'd200, 12'd200);
    add_item(OP_SHADE, 2'd0, 16'd0, 16'd0, 24'sd0, 8'd0, 8'd0, 8'd0, 12'd100, 12'd250);
    // degenerate triangle, a single point
    add_item(OP_LOAD, 2'd0, 16'd16, 16'd16, 24'sd0, 8'hAA, 8'h55, 8'hAA, 12'd0, 12'd0);
    add_item(OP_LOAD, 2'd1, 16'd16, 16'd16, 24'sd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
    add_item(OP_LOAD, 2'd2, 16'd16, 16'd16, 24'sd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
    add_item(OP_SHADE, 2'd0, 16'd0, 16'd0, 24'sd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
    n = pending_items.size();
    // random: mostly triangles with pixels in their box, some noise
    while (n < 1850) begin
      case ($urandom_range(0, 9))
        0: n += add_triangle($urandom_range(1, 8), 1'b1, 1'b0);
        1: n += add_triangle($urandom_range(1, 4), 1'b0, 1'b1);
        2: begin
          add_item(op_t'($urandom_range(1, 2)), 2'($urandom), 16'($urandom), 16'($urandom),
                   24'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   12'($urandom), 12'($urandom));
          add_item(OP_CLEAR, 2'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom),
                   12'($urandom_range(0, 255)), 12'($urandom_range(0, 255)));
          add_item(OP_NONE, 2'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom),
                   12'($urandom), 12'($urandom));
          n += 3;
        end
        default: n += add_triangle($urandom_range(2, 12), 1'b0, 1'b0);
      endcase
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (pending_items.size() == 0 && !in_valid && expected_pixels.size() == 0);
    repeat (300) @(posedge clk);
    $display("covered %0d items: %0d pixels written, %0d partial coverage, %0d uncovered",
             accepted, n_written, n_partial, n_uncovered);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_pixels.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
